/* src/msed_pkg.sv */
// ----------------------------------------------------------------------------
// msed_pkg
// Shared types, constants and helpers of the music sequence event decoder.
// ----------------------------------------------------------------------------
package msed_pkg;

   localparam int TIME_WIDTH       = 24;
   localparam int ADD_WIDTH        = 11;
   localparam int CH_WIDTH         = 4;
   localparam int PITCH_WIDTH      = 9;
   localparam int BYTE_WIDTH       = 8;
   localparam int RSP_DATA_WIDTH   = 72;
   localparam int DEF_TABLE_DEPTH  = 256;
   localparam int DEF_CHANNELS     = 16;
   localparam int PITCH_OFFSET     = 21;
   localparam int ROW_TICKS        = 6;
   localparam int OFF_SPAN         = 16;
   localparam int CMD_SPAN         = 32;
   localparam logic [BYTE_WIDTH-1:0] END_CODE = 8'hFE;

   localparam logic [2:0] CLS_PLAY  = 3'd0;
   localparam logic [2:0] CLS_OFF   = 3'd1;
   localparam logic [2:0] CLS_INSTR = 3'd2;
   localparam logic [2:0] CLS_ROW   = 3'd3;
   localparam logic [2:0] CLS_END   = 3'd4;

   localparam logic [1:0] SEL_TABLE = 2'd0;
   localparam logic [1:0] SEL_OFF   = 2'd1;
   localparam logic [1:0] SEL_SCAN  = 2'd2;

   localparam logic REC_NOTE = 1'b0;
   localparam logic REC_END  = 1'b1;

   typedef struct packed {
      logic       accept;
      logic       clear;
      logic       acc_count;
      logic       acc_chan;
      logic       acc_note;
      logic       acc_operand;
      logic       acc_instr;
      logic       acc_row;
      logic       play_start;
      logic       emit;
      logic       emit_last;
      logic       end_rec;
      logic       scan_clr;
      logic       scan_inc;
      logic [1:0] sel;
   } msed_cmd_type;

   typedef struct packed {
      logic [2:0] cls;
      logic       count_zero;
      logic       load_done;
      logic       instr_ok;
      logic       ch_ok;
      logic       sounding;
      logic       out_free;
      logic       scan_last;
   } msed_status_type;

   function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                     input logic [ADD_WIDTH-1:0] b);
      logic [TIME_WIDTH:0] s;
      s = {1'b0, a} + {{(TIME_WIDTH+1-ADD_WIDTH){1'b0}}, b};
      return s[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : s[TIME_WIDTH-1:0];
   endfunction

endpackage

/* src/music_sequence_event_decoder_top.sv */
// ----------------------------------------------------------------------------
// music_sequence_event_decoder_top
// Decodes song sequence bytes into note event and end records.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one sequence byte per transaction in req_tdata;
//   req_tuser high marks the first byte of a song (the note count) and clears
//   all per-channel state. The header bytes fill an on-chip note table.
//   The rsp channel returns note events and the end record; rsp_tuser is the
//   record kind and rsp_tlast marks the last record caused by a byte.
//   Play and note off bytes pass through a further state for the table
//   read or channel lookup before the next byte is taken. An end byte
//   scans the channels one per cycle, unless a sounding channel's record
//   waits on a full output register, and then sends the end record.
//   Records are held in an output register; a stalled receiver holds the
//   decoder at its next record while the register is full.
//   Reset clears the parse phase and channel state; the note table holds
//   whatever was written by the current song header.
// ----------------------------------------------------------------------------
module music_sequence_event_decoder_top
   import msed_pkg::*;
#(
   parameter int NOTE_TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int CHANNELS         = DEF_CHANNELS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [BYTE_WIDTH-1:0]     req_tdata,  // [7:0] seq_byte
   input  logic                      req_tuser,  // [0] song_start
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [3:0] channel, [12:4] pitch, [36:13] note_length, [60:37] rest_delay,
   // [61] first_after_change, [69:62] instrument, [71:70] zero
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tuser,  // [0] record_kind
   output logic                      rsp_tlast
);

   msed_cmd_type    cmd;
   msed_status_type sts;

   msed_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   msed_dpath #(
      .NOTE_TABLE_DEPTH (NOTE_TABLE_DEPTH),
      .CHANNELS         (CHANNELS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* src/msed_ram.sv */
// ----------------------------------------------------------------------------
// msed_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module msed_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/msed_ctrl.sv */
// ----------------------------------------------------------------------------
// msed_ctrl
// Parse phase and sequencing of one sequence byte at a time.
// ----------------------------------------------------------------------------
module msed_ctrl
   import msed_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic            req_tuser,
   input  msed_status_type sts,
   output msed_cmd_type    cmd
);

   localparam logic [2:0] PH_COUNT   = 3'd0;
   localparam logic [2:0] PH_CHAN    = 3'd1;
   localparam logic [2:0] PH_NOTE    = 3'd2;
   localparam logic [2:0] PH_BODY    = 3'd3;
   localparam logic [2:0] PH_OPERAND = 3'd4;
   localparam logic [2:0] PH_DONE    = 3'd5;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PLAY   = 3'd1;
   localparam logic [2:0] S_OFF    = 3'd2;
   localparam logic [2:0] S_END    = 3'd3;
   localparam logic [2:0] S_ENDREC = 3'd4;

   logic [2:0] phase_ff, phase_in;
   logic [2:0] state_ff, state_in;
   logic [2:0] ph;
   logic       acc;

   assign req_tready = (state_ff == S_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign ph         = req_tuser ? PH_COUNT : phase_ff;

   always_comb begin
      cmd      = '0;
      phase_in = phase_ff;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               cmd.accept = 1'b1;
               cmd.clear  = req_tuser;
               unique case (ph)
                  PH_COUNT: begin
                     cmd.acc_count = 1'b1;
                     phase_in = sts.count_zero ? PH_BODY : PH_CHAN;
                  end
                  PH_CHAN: begin
                     cmd.acc_chan = 1'b1;
                     if (sts.load_done) phase_in = PH_NOTE;
                  end
                  PH_NOTE: begin
                     cmd.acc_note = 1'b1;
                     if (sts.load_done) phase_in = PH_BODY;
                  end
                  PH_OPERAND: begin
                     cmd.acc_operand = 1'b1;
                     phase_in = PH_BODY;
                  end
                  PH_BODY: begin
                     unique case (sts.cls)
                        CLS_PLAY:  state_in = S_PLAY;
                        CLS_OFF:   state_in = S_OFF;
                        CLS_INSTR: begin
                           if (sts.instr_ok) begin
                              cmd.acc_instr = 1'b1;
                              phase_in = PH_OPERAND;
                           end
                        end
                        CLS_ROW:   cmd.acc_row = 1'b1;
                        default: begin
                           cmd.scan_clr = 1'b1;
                           state_in = S_END;
                        end
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         S_PLAY: begin
            cmd.sel = SEL_TABLE;
            if (!sts.ch_ok) begin
               state_in = S_IDLE;
            end else if (!sts.sounding) begin
               cmd.play_start = 1'b1;
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_last  = 1'b1;
               cmd.play_start = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_OFF: begin
            cmd.sel = SEL_OFF;
            if (!(sts.ch_ok && sts.sounding)) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_END: begin
            cmd.sel = SEL_SCAN;
            if (!sts.sounding || sts.out_free) begin
               cmd.emit = sts.sounding;
               if (sts.scan_last) state_in = S_ENDREC;
               else               cmd.scan_inc = 1'b1;
            end
         end
         S_ENDREC: begin
            if (sts.out_free) begin
               cmd.end_rec = 1'b1;
               phase_in = PH_DONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         state_ff <= S_IDLE;
      end else begin
         phase_ff <= phase_in;
         state_ff <= state_in;
      end
   end

endmodule

/* src/msed_dpath.sv */
// ----------------------------------------------------------------------------
// msed_dpath
// Note table, per-channel note state, time accumulation and result register.
// ----------------------------------------------------------------------------
module msed_dpath
   import msed_pkg::*;
#(
   parameter int NOTE_TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int CHANNELS         = DEF_CHANNELS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [BYTE_WIDTH-1:0]     req_tdata,
   input  msed_cmd_type              cmd,
   output msed_status_type           sts,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   localparam int AW = $clog2(NOTE_TABLE_DEPTH);
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [BYTE_WIDTH-1:0]  note_count_ff, note_count_in;
   logic [BYTE_WIDTH-1:0]  load_index_ff, load_index_in;
   logic [BYTE_WIDTH-1:0]  byte_ff, byte_in;
   logic [CW-1:0]          pending_ff, pending_in;
   logic [CW-1:0]          scan_ff, scan_in;

   logic [CHANNELS-1:0]    active_ff, active_in;
   logic [CHANNELS-1:0]    sounding_ff, sounding_in;
   logic [CHANNELS-1:0]    first_ff, first_in;
   logic [PITCH_WIDTH-1:0] pitch_ff [CHANNELS];
   logic [PITCH_WIDTH-1:0] pitch_in [CHANNELS];
   logic [TIME_WIDTH-1:0]  length_ff [CHANNELS];
   logic [TIME_WIDTH-1:0]  length_in [CHANNELS];
   logic [TIME_WIDTH-1:0]  delay_ff [CHANNELS];
   logic [TIME_WIDTH-1:0]  delay_in [CHANNELS];
   logic [BYTE_WIDTH-1:0]  instr_ff [CHANNELS];
   logic [BYTE_WIDTH-1:0]  instr_in [CHANNELS];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [CH_WIDTH-1:0]    ram_ch;
   logic [BYTE_WIDTH-1:0]  ram_note;
   logic                   idx_ok;
   logic                   rd_ok;
   logic                   tab_wr;

   logic [BYTE_WIDTH:0]    diff;
   logic [BYTE_WIDTH:0]    bdiff;
   logic [BYTE_WIDTH-1:0]  rt;
   logic [ADD_WIDTH-1:0]   add;
   logic [BYTE_WIDTH-1:0]  next_index;
   logic [CH_WIDTH-1:0]    req_ch;
   logic [CH_WIDTH-1:0]    instr_ch;
   logic [CH_WIDTH-1:0]    cur_ch;
   logic [BYTE_WIDTH-1:0]  cur_note;
   logic [CW-1:0]          cur_idx;
   logic [2:0]             cls;

   // note table
   assign idx_ok = {1'b0, load_index_ff} < (BYTE_WIDTH+1)'(NOTE_TABLE_DEPTH);
   assign tab_wr = idx_ok && (cmd.acc_chan || cmd.acc_note);

   msed_ram #(.WIDTH(CH_WIDTH), .DEPTH(NOTE_TABLE_DEPTH)) u_ch_ram (
      .clock   (clock),
      .wr_en   (tab_wr && cmd.acc_chan),
      .wr_addr (load_index_ff[AW-1:0]),
      .wr_data (req_tdata[CH_WIDTH-1:0]),
      .rd_en   (cmd.accept),
      .rd_addr (req_tdata[AW-1:0]),
      .rd_data (ram_ch)
   );

   msed_ram #(.WIDTH(BYTE_WIDTH), .DEPTH(NOTE_TABLE_DEPTH)) u_note_ram (
      .clock   (clock),
      .wr_en   (tab_wr && cmd.acc_note),
      .wr_addr (load_index_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (cmd.accept),
      .rd_addr (req_tdata[AW-1:0]),
      .rd_data (ram_note)
   );

   // byte classification
   assign diff     = {1'b0, req_tdata} - {1'b0, note_count_ff};
   assign bdiff    = {1'b0, byte_ff} - {1'b0, note_count_ff};
   assign rt       = BYTE_WIDTH'(diff - (BYTE_WIDTH+1)'(CMD_SPAN));
   assign add      = ADD_WIDTH'(rt) * ADD_WIDTH'(ROW_TICKS);
   assign next_index = load_index_ff + 8'd1;
   assign req_ch   = req_tdata[CH_WIDTH-1:0];
   assign instr_ch = CH_WIDTH'(diff - (BYTE_WIDTH+1)'(OFF_SPAN));
   assign rd_ok    = {1'b0, byte_ff} < (BYTE_WIDTH+1)'(NOTE_TABLE_DEPTH);

   always_comb begin
      priority if (req_tdata < note_count_ff)         cls = CLS_PLAY;
      else if (diff < (BYTE_WIDTH+1)'(OFF_SPAN))      cls = CLS_OFF;
      else if (diff < (BYTE_WIDTH+1)'(CMD_SPAN))      cls = CLS_INSTR;
      else if (req_tdata < END_CODE)                  cls = CLS_ROW;
      else                                            cls = CLS_END;
   end

   always_comb begin
      unique case (cmd.sel)
         SEL_TABLE: begin
            cur_ch   = rd_ok ? ram_ch : '0;
            cur_note = rd_ok ? ram_note : '0;
         end
         SEL_OFF: begin
            cur_ch   = bdiff[CH_WIDTH-1:0];
            cur_note = '0;
         end
         default: begin
            cur_ch   = CH_WIDTH'(scan_ff);
            cur_note = '0;
         end
      endcase
   end

   assign cur_idx        = cur_ch[CW-1:0];
   assign sts.cls        = cls;
   assign sts.count_zero = (req_tdata == '0);
   assign sts.load_done  = (next_index >= note_count_ff);
   assign sts.instr_ok   = {1'b0, instr_ch} < (CH_WIDTH+1)'(CHANNELS);
   assign sts.ch_ok      = {1'b0, cur_ch} < (CH_WIDTH+1)'(CHANNELS);
   assign sts.sounding   = sts.ch_ok && sounding_ff[cur_idx];
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;
   assign sts.scan_last  = (scan_ff == CW'(CHANNELS-1));

   // per-channel state
   always_comb begin
      active_in   = active_ff;
      sounding_in = sounding_ff;
      first_in    = first_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         pitch_in[c]  = pitch_ff[c];
         length_in[c] = length_ff[c];
         delay_in[c]  = delay_ff[c];
         instr_in[c]  = instr_ff[c];
      end
      if (cmd.clear) begin
         active_in   = '0;
         sounding_in = '0;
         first_in    = '1;
         for (int c = 0; c < CHANNELS; c++) begin
            pitch_in[c]  = '0;
            length_in[c] = '0;
            delay_in[c]  = '0;
            instr_in[c]  = '0;
         end
      end
      if (cmd.acc_chan && ({1'b0, req_ch} < (CH_WIDTH+1)'(CHANNELS))) begin
         active_in[req_ch[CW-1:0]] = 1'b1;
      end
      if (cmd.acc_operand && (instr_ff[pending_ff] != req_tdata)) begin
         instr_in[pending_ff] = req_tdata;
         first_in[pending_ff] = 1'b1;
      end
      if (cmd.acc_row) begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (active_ff[c]) begin
               if (sounding_ff[c]) length_in[c] = sat_add(length_ff[c], add);
               else                delay_in[c]  = sat_add(delay_ff[c], add);
            end
         end
      end
      if (cmd.emit) begin
         first_in[cur_idx]    = 1'b0;
         delay_in[cur_idx]    = '0;
         sounding_in[cur_idx] = 1'b0;
      end
      if (cmd.play_start) begin
         pitch_in[cur_idx]    = PITCH_WIDTH'(cur_note) + PITCH_WIDTH'(PITCH_OFFSET);
         sounding_in[cur_idx] = 1'b1;
         length_in[cur_idx]   = '0;
      end
   end

   // parse registers
   always_comb begin
      note_count_in = note_count_ff;
      load_index_in = load_index_ff;
      pending_in    = pending_ff;
      byte_in       = cmd.accept ? req_tdata : byte_ff;
      scan_in       = scan_ff;
      if (cmd.acc_count) begin
         note_count_in = req_tdata;
         load_index_in = '0;
      end
      if (cmd.acc_chan || cmd.acc_note) begin
         load_index_in = sts.load_done ? '0 : next_index;
      end
      if (cmd.acc_instr) pending_in = instr_ch[CW-1:0];
      if (cmd.scan_clr)  scan_in = '0;
      if (cmd.scan_inc)  scan_in = scan_ff + CW'(1);
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = REC_NOTE;
         rsp_last_in  = cmd.emit_last;
         rsp_data_in  = {2'b00, instr_ff[cur_idx], first_ff[cur_idx], delay_ff[cur_idx],
                         length_ff[cur_idx], pitch_ff[cur_idx], cur_ch};
      end else if (cmd.end_rec) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = REC_END;
         rsp_last_in  = 1'b1;
         rsp_data_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         note_count_ff <= '0;
         load_index_ff <= '0;
         pending_ff    <= '0;
         scan_ff       <= '0;
         active_ff     <= '0;
         sounding_ff   <= '0;
         first_ff      <= '1;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            pitch_ff[c]  <= '0;
            length_ff[c] <= '0;
            delay_ff[c]  <= '0;
            instr_ff[c]  <= '0;
         end
      end else begin
         note_count_ff <= note_count_in;
         load_index_ff <= load_index_in;
         pending_ff    <= pending_in;
         scan_ff       <= scan_in;
         active_ff     <= active_in;
         sounding_ff   <= sounding_in;
         first_ff      <= first_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int c = 0; c < CHANNELS; c++) begin
            pitch_ff[c]  <= pitch_in[c];
            length_ff[c] <= length_in[c];
            delay_ff[c]  <= delay_in[c];
            instr_ff[c]  <= instr_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
